// ===== rtl/recon_gain_info_parser_defines.svh =====
// Assertion macros shared by the recon gain info parser RTL.
`ifndef RECON_GAIN_INFO_PARSER_DEFINES_SVH
`define RECON_GAIN_INFO_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define RGIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgip: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define RGIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgip: next-cycle check failed");
`else
`define RGIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RGIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rgip_pkg.sv =====
// Shared constants, types and layer search function of the recon gain info parser.
package rgip_pkg;

  localparam int unsigned MAX_LAYERS    = 6;
  localparam int unsigned CHANNELS      = 12;
  localparam int unsigned MAX_LEB_BYTES = 8;

  // Field widths
  localparam int unsigned LAYER_W = 3;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned FLAG_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MASK_W  = 6;
  localparam int unsigned LCNT_W  = 3;

  // APB port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [0:0] {
    REG_PRESENT_MASK = 1'b0,
    REG_LAYER_COUNT  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_ZEROS,
    ST_ERROR
  } state_e;

  typedef struct packed {
    logic [MASK_W-1:0] present_mask;
    logic [LCNT_W-1:0] layer_count;
  } cfg_t;

  typedef struct packed {
    logic               found;
    logic [LAYER_W-1:0] idx;
  } layer_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic flag_load;
    logic byte_load;
    logic emit_gain;
    logic emit_zero;
    logic emit_err;
    logic close_layer;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic phase_gain;
    logic layer_found;
    logic leb_error;
    logic leb_more;
    logic ch_end;
    logic flag_set;
    logic slot_free;
  } dp_sts_t;

  // Lowest present layer at or above from, below the clamped layer count
  function automatic layer_sel_t next_present(logic [LAYER_W:0]   from,
                                              logic [MASK_W-1:0]  mask,
                                              logic [LCNT_W-1:0]  count);
    layer_sel_t       sel;
    logic [LAYER_W:0] eff;
    sel = '0;
    eff = (int'(count) > MAX_LAYERS) ? (LAYER_W+1)'(MAX_LAYERS) : {1'b0, count};
    for (int l = MASK_W - 1; l >= 0; l--) begin
      if ((l < MAX_LAYERS) && ((LAYER_W+1)'(l) >= from) &&
          ((LAYER_W+1)'(l) < eff) && mask[l]) begin
        sel.found = 1'b1;
        sel.idx   = LAYER_W'(l);
      end
    end
    return sel;
  endfunction

endpackage

// ===== rtl/rgip_regs.sv =====
// APB configuration registers of the recon gain info parser.
module rgip_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgip_pkg::APB_AW-1:0]   paddr,
  input  logic [rgip_pkg::APB_DW-1:0]   pwdata,
  output logic [rgip_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output rgip_pkg::cfg_t                cfg_o
);

  rgip_pkg::cfg_t     cfg_q, cfg_d;
  rgip_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign reg_idx = rgip_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write the addressed register on the access phase
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        rgip_pkg::REG_PRESENT_MASK: cfg_d.present_mask = pwdata[rgip_pkg::MASK_W-1:0];
        rgip_pkg::REG_LAYER_COUNT:  cfg_d.layer_count  = pwdata[rgip_pkg::LCNT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      rgip_pkg::REG_PRESENT_MASK:
        prdata = rgip_pkg::APB_DW'(cfg_q.present_mask);
      rgip_pkg::REG_LAYER_COUNT:
        prdata = rgip_pkg::APB_DW'(cfg_q.layer_count);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rgip_dp.sv =====
// Datapath of the recon gain info parser: flag decode, channel walk, result register.
`include "recon_gain_info_parser_defines.svh"

module rgip_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rgip_pkg::cfg_t                 cfg_i,
  input  logic [rgip_pkg::BYTE_W-1:0]    data_byte_i,
  input  rgip_pkg::dp_cmd_t              cmd_i,
  output rgip_pkg::dp_sts_t              sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [rgip_pkg::LAYER_W-1:0]   layer_o,
  output logic [rgip_pkg::CH_W-1:0]      channel_o,
  output logic [rgip_pkg::BYTE_W-1:0]    gain_o,
  output logic [rgip_pkg::FLAG_W-1:0]    flag_word_o,
  output logic                           layer_done_o,
  output logic                           unit_done_o,
  output logic                           error_o
);

  localparam int unsigned LAYER_W = rgip_pkg::LAYER_W;
  localparam int unsigned CH_W    = rgip_pkg::CH_W;
  localparam int unsigned CNT_W   = rgip_pkg::CNT_W;
  localparam int unsigned FLAG_W  = rgip_pkg::FLAG_W;
  localparam int unsigned BYTE_W  = rgip_pkg::BYTE_W;

  // Parser state
  logic               phase_q, phase_d;
  logic [LAYER_W-1:0] layer_q, layer_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FLAG_W-1:0]  flag_q, flag_d;
  logic               ovf_q, ovf_d;
  logic [BYTE_W-1:0]  byte_q;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [LAYER_W-1:0] res_layer_q;
  logic [CH_W-1:0]    res_ch_q;
  logic [BYTE_W-1:0]  res_gain_q;
  logic [FLAG_W-1:0]  res_flag_q;
  logic               res_ld_q, res_ud_q, res_err_q;

  rgip_pkg::layer_sel_t sel_cur, sel_zero, sel_next, sel_flag;
  logic [LAYER_W-1:0]   first_layer;
  logic                 cont;
  logic [5:0]           sh_amt;
  logic [63:0]          part;
  logic                 ovf_new;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 leb_error;
  logic [FLAG_W-1:0]    flag_sh;
  logic                 last_ch;
  logic                 emit_any;
  logic                 slot_free;
  logic                 rearmed;

  // Layer searches from the current layer, from zero and past the current layer
  always_comb begin
    sel_cur  = rgip_pkg::next_present({1'b0, layer_q}, cfg_i.present_mask,
                                      cfg_i.layer_count);
    sel_zero = rgip_pkg::next_present('0, cfg_i.present_mask, cfg_i.layer_count);
    sel_next = rgip_pkg::next_present({1'b0, layer_q} + (LAYER_W+1)'(1),
                                      cfg_i.present_mask, cfg_i.layer_count);
    sel_flag = sel_cur.found ? sel_cur : sel_zero;
    first_layer = sel_zero.found ? sel_zero.idx : '0;
  end

  // Place the next seven flag bits and check for overflow and overlength
  assign cont      = data_byte_i[BYTE_W-1];
  assign sh_amt    = 6'({2'b00, cnt_q} * 6'd7);
  assign part      = 64'(data_byte_i[6:0]) << sh_amt;
  assign ovf_new   = ovf_q | (|part[63:32]);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign leb_error = (int'(cnt_q) >= rgip_pkg::MAX_LEB_BYTES) ||
                     (cont && (int'(cnt_inc) >= rgip_pkg::MAX_LEB_BYTES)) ||
                     (!cont && ovf_new);

  assign flag_sh   = flag_q >> ch_q;
  assign last_ch   = (ch_q == CH_W'(rgip_pkg::CHANNELS - 1));
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_any  = cmd_i.emit_gain | cmd_i.emit_zero | cmd_i.emit_err;
  assign rearmed   = !phase_q && (cnt_q == '0) && (flag_q == '0);

  // Status for the controller
  always_comb begin
    sts_o.phase_gain  = phase_q;
    sts_o.layer_found = sel_flag.found;
    sts_o.leb_error   = leb_error;
    sts_o.leb_more    = cont && !leb_error;
    sts_o.ch_end      = (int'(ch_q) >= rgip_pkg::CHANNELS);
    sts_o.flag_set    = flag_sh[0];
    sts_o.slot_free   = slot_free;
  end

  // Next parser state
  always_comb begin
    phase_d = phase_q;
    layer_d = layer_q;
    ch_d    = ch_q;
    cnt_d   = cnt_q;
    flag_d  = flag_q;
    ovf_d   = ovf_q;
    if (cmd_i.flag_load) begin
      layer_d = sel_flag.idx;
      flag_d  = flag_q | part[FLAG_W-1:0];
      cnt_d   = cnt_inc;
      ovf_d   = ovf_new;
      if (!cont && !leb_error) begin
        phase_d = 1'b1;
        ch_d    = '0;
      end
    end
    if (cmd_i.emit_gain || cmd_i.emit_zero) begin
      ch_d = ch_q + CH_W'(1);
    end
    // Close the layer: move to the next present one or rearm
    if (cmd_i.close_layer || cmd_i.emit_err) begin
      phase_d = 1'b0;
      ch_d    = '0;
      cnt_d   = '0;
      flag_d  = '0;
      ovf_d   = 1'b0;
      layer_d = (cmd_i.close_layer && sel_next.found) ? sel_next.idx : first_layer;
    end
  end

  assign out_valid_d = emit_any ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      layer_q     <= '0;
      ch_q        <= '0;
      cnt_q       <= '0;
      flag_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      layer_q     <= layer_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      flag_q      <= flag_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the gain byte and load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_load) begin
      byte_q <= data_byte_i;
    end
    if (cmd_i.emit_err) begin
      res_layer_q <= layer_q;
      res_ch_q    <= '0;
      res_gain_q  <= '0;
      res_flag_q  <= '0;
      res_ld_q    <= 1'b0;
      res_ud_q    <= 1'b1;
      res_err_q   <= 1'b1;
    end else if (cmd_i.emit_gain || cmd_i.emit_zero) begin
      res_layer_q <= layer_q;
      res_ch_q    <= ch_q;
      res_gain_q  <= cmd_i.emit_gain ? byte_q : '0;
      res_flag_q  <= flag_q;
      res_ld_q    <= last_ch;
      res_ud_q    <= last_ch && !sel_next.found;
      res_err_q   <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign layer_o      = res_layer_q;
  assign channel_o    = res_ch_q;
  assign gain_o       = res_gain_q;
  assign flag_word_o  = res_flag_q;
  assign layer_done_o = res_ld_q;
  assign unit_done_o  = res_ud_q;
  assign error_o      = res_err_q;

  `RGIP_ASSERT_IMP(a_ch_range, clk_i, rst_ni, 1'b1, int'(ch_q) <= rgip_pkg::CHANNELS)
  `RGIP_ASSERT_IMP(a_gain_no_ovf, clk_i, rst_ni, phase_q, !ovf_q)
  `RGIP_ASSERT_IMP(a_err_ends_unit, clk_i, rst_ni, out_valid_q && res_err_q, res_ud_q)
  `RGIP_ASSERT_NXT(a_err_rearms, clk_i, rst_ni, cmd_i.emit_err, rearmed)

endmodule

// ===== rtl/rgip_ctrl.sv =====
// Controller state machine of the recon gain info parser.
`include "recon_gain_info_parser_defines.svh"

module rgip_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rgip_pkg::dp_sts_t     sts_i,
  output rgip_pkg::dp_cmd_t     cmd_o
);

  rgip_pkg::state_e state_q, state_d;
  logic [2:0]       emit_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgip_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence flag decode, gain emission, the zero-gain walk and error emission
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rgip_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!sts_i.phase_gain) begin
            // Drop the byte when no layer is present
            if (sts_i.layer_found) begin
              cmd_o.flag_load = 1'b1;
              if (sts_i.leb_error) begin
                state_d = rgip_pkg::ST_ERROR;
              end else if (!sts_i.leb_more) begin
                state_d = rgip_pkg::ST_ZEROS;
              end
            end
          end else if (sts_i.ch_end) begin
            state_d = rgip_pkg::ST_ZEROS;
          end else begin
            cmd_o.byte_load = 1'b1;
            state_d         = rgip_pkg::ST_GAIN;
          end
        end
      end
      rgip_pkg::ST_GAIN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_gain = 1'b1;
          state_d         = rgip_pkg::ST_ZEROS;
        end
      end
      rgip_pkg::ST_ZEROS: begin
        if (sts_i.ch_end) begin
          cmd_o.close_layer = 1'b1;
          state_d           = rgip_pkg::ST_IDLE;
        end else if (!sts_i.flag_set) begin
          cmd_o.emit_zero = sts_i.slot_free;
        end else begin
          state_d = rgip_pkg::ST_IDLE;
        end
      end
      rgip_pkg::ST_ERROR: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = rgip_pkg::ST_IDLE;
        end
      end
      default: state_d = rgip_pkg::ST_IDLE;
    endcase
  end

  assign emit_vec = {cmd_o.emit_gain, cmd_o.emit_zero, cmd_o.emit_err};

  `RGIP_ASSERT_IMP(a_one_emit, clk_i, rst_ni, 1'b1, $onehot0(emit_vec))
  `RGIP_ASSERT_IMP(a_gain_in_range, clk_i, rst_ni, state_q == rgip_pkg::ST_GAIN, !sts_i.ch_end)
  `RGIP_ASSERT_IMP(a_err_phase, clk_i, rst_ni, state_q == rgip_pkg::ST_ERROR, !sts_i.phase_gain)

endmodule

// ===== rtl/recon_gain_info_parser.sv =====
// A gain byte is held in a register in IDLE; its result is registered from GAIN once the
// output slot is free. A final flag byte starts the zero-gain walk the next cycle. ZEROS
// emits a zero-gain result per clear flag bit while the slot is free, and stops at a set
// bit or closes the layer (controller FSM). New bytes are accepted only in IDLE.
// Reset: asynchronous, active low; clears the FSM, parser state, result valid and
// configuration registers.
module recon_gain_info_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rgip_pkg::APB_AW-1:0]    paddr,
  input  logic [rgip_pkg::APB_DW-1:0]    pwdata,
  output logic [rgip_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rgip_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rgip_pkg::LAYER_W-1:0]   layer_o,
  output logic [rgip_pkg::CH_W-1:0]      channel_o,
  output logic [rgip_pkg::BYTE_W-1:0]    gain_o,
  output logic [rgip_pkg::FLAG_W-1:0]    flag_word_o,
  output logic                           layer_done_o,
  output logic                           unit_done_o,
  output logic                           error_o
);

  rgip_pkg::cfg_t    cfg;
  rgip_pkg::dp_cmd_t cmd;
  rgip_pkg::dp_sts_t sts;

  rgip_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rgip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rgip_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .data_byte_i  (data_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .layer_o      (layer_o),
    .channel_o    (channel_o),
    .gain_o       (gain_o),
    .flag_word_o  (flag_word_o),
    .layer_done_o (layer_done_o),
    .unit_done_o  (unit_done_o),
    .error_o      (error_o)
  );

endmodule
